[sv/ppt_pkg.sv]
// Shared constants and types of the projective point transform.
package ppt_pkg;

   localparam int NUM_REGS  = 8;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 64;
   localparam int COORD_W   = 32;
   localparam int PROD_W    = 64;
   localparam int FRAC_W    = 16;
   localparam int NUM_W     = 50;
   localparam int REM_W     = NUM_W + 1;
   localparam int QBITS     = 33;
   localparam int DIV_STEP  = 3;
   localparam int DIV_STAGES = QBITS / DIV_STEP;
   localparam int PRE_SHIFT = QBITS - FRAC_W;

   localparam logic [CSR_DAT_W-1:0] REG_RESET [NUM_REGS] = '{
      64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
   };

   localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

   // State of the three coordinate divisions as it moves down the divider.
   typedef struct packed {
      logic [2:0][REM_W-1:0] rem;
      logic [2:0][QBITS-1:0] quo;
      logic [2:0][QBITS-1:0] dbits;
      logic [NUM_W-1:0]      den;
      logic [2:0]            neg;
      logic [2:0]            big;
      logic                  wz;
   } div_type;

endpackage

[sv/ppt_channels.sv]
// Channel interfaces of the projective point transform.
interface ppt_req_if import ppt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] point_x;
   logic [COORD_W-1:0] point_y;
   logic [COORD_W-1:0] point_z;
   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppt_rsp_if import ppt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] out_x;
   logic [COORD_W-1:0] out_y;
   logic [COORD_W-1:0] out_z;
   logic               w_zero;
   logic               overflow;
   modport source (output valid, out_x, out_y, out_z, w_zero, overflow, input ready);
   modport sink (input valid, out_x, out_y, out_z, w_zero, overflow, output ready);
endinterface

interface ppt_csr_if import ppt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[sv/projective_point_transform_top.sv]
// Top level of the projective point transform with perspective divide.
//
// The block multiplies a point (x, y, z, 1) in signed Q16.16 by a 4x4 matrix
// held in eight 64-bit registers and divides x, y and z by the resulting w.
// Items arrive on req_ch and leave on rsp_ch; each item gives one result.
// The matrix is written through csr_ch, which is always ready; a write to an
// index beyond the eight registers is dropped. Write it only while idle.
// The pipeline has fifteen register stages: products, column sums, operand
// preparation, eleven divider stages of three quotient bits each, and the
// output register. Throughput is one item per cycle while the receiver takes
// results; the pipeline depth sets the latency. When the receiver stalls
// with a result waiting, the whole pipeline holds and req_ch.ready drops;
// no item is lost or repeated.
// A zero w gives zero coordinates with w_zero set; a quotient outside the
// 32-bit range saturates and sets overflow.
// Reset loads the identity matrix and empties the pipeline.
module projective_point_transform_top
   import ppt_pkg::*;
(
   input logic clock,
   input logic reset,
   ppt_req_if.sink   req_ch,
   ppt_rsp_if.source rsp_ch,
   ppt_csr_if.sink   csr_ch
);

   logic [CSR_DAT_W-1:0] mat_ff [NUM_REGS];
   logic signed [COORD_W-1:0] m [4][4];
   logic adv;

   // Matrix registers.
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= REG_RESET;
      end else if (csr_ch.valid && csr_ch.index < CSR_IDX_W'(NUM_REGS)) begin
         mat_ff[csr_ch.index[2:0]] <= csr_ch.data;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         m[r][0] = mat_ff[r*2][31:0];
         m[r][1] = mat_ff[r*2][63:32];
         m[r][2] = mat_ff[r*2+1][31:0];
         m[r][3] = mat_ff[r*2+1][63:32];
      end
   end

   // The whole pipeline moves whenever the output register can take a result.
   assign adv = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Stage 1: the twelve exact products.
   logic signed [PROD_W-1:0] prod_ff [4][3];
   logic v1_ff;
   logic signed [COORD_W-1:0] pt [3];
   assign pt[0] = req_ch.point_x;
   assign pt[1] = req_ch.point_y;
   assign pt[2] = req_ch.point_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_ch.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 3; r++) begin
               prod_ff[c][r] <= PROD_W'(pt[r] * m[r][c]);
            end
         end
      end
   end

   // Stage 2: column sums of floored products plus the bottom row.
   logic signed [NUM_W-1:0] sum_ff [4];
   logic v2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 4; c++) begin
            sum_ff[c] <= NUM_W'(m[3][c])
               + NUM_W'(prod_ff[c][0] >>> FRAC_W)
               + NUM_W'(prod_ff[c][1] >>> FRAC_W)
               + NUM_W'(prod_ff[c][2] >>> FRAC_W);
         end
      end
   end

   // Stage 3: magnitudes, signs and the early overflow test.
   div_type dst_ff [DIV_STAGES+1];
   logic [DIV_STAGES:0] dv_ff;
   div_type prep;
   logic [NUM_W-1:0] amag;

   always_comb begin
      prep = '0;
      amag = '0;
      prep.den = sum_ff[3][NUM_W-1] ? NUM_W'(-sum_ff[3]) : NUM_W'(sum_ff[3]);
      prep.wz  = (sum_ff[3] == '0);
      for (int c = 0; c < 3; c++) begin
         amag = sum_ff[c][NUM_W-1] ? NUM_W'(-sum_ff[c]) : NUM_W'(sum_ff[c]);
         prep.neg[c]   = sum_ff[c][NUM_W-1] ^ sum_ff[3][NUM_W-1];
         prep.big[c]   = (amag >> PRE_SHIFT) >= prep.den;
         prep.rem[c]   = REM_W'(amag >> PRE_SHIFT);
         prep.dbits[c] = {amag[PRE_SHIFT-1:0], {FRAC_W{1'b0}}};
         prep.quo[c]   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= v2_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         dst_ff[0] <= prep;
      end
   end

   // Divider stages: restoring division, several quotient bits per stage.
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      div_type dnext;
      always_comb begin
         dnext = dst_ff[k];
         for (int c = 0; c < 3; c++) begin
            for (int j = 0; j < DIV_STEP; j++) begin
               dnext.rem[c]   = {dnext.rem[c][REM_W-2:0], dnext.dbits[c][QBITS-1]};
               dnext.dbits[c] = {dnext.dbits[c][QBITS-2:0], 1'b0};
               if (dnext.rem[c] >= {1'b0, dnext.den}) begin
                  dnext.rem[c] = dnext.rem[c] - {1'b0, dnext.den};
                  dnext.quo[c] = {dnext.quo[c][QBITS-2:0], 1'b1};
               end else begin
                  dnext.quo[c] = {dnext.quo[c][QBITS-2:0], 1'b0};
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dst_ff[k+1] <= dnext;
         end
      end
   end

   // Output stage: sign, saturation and the zero-w case.
   logic [COORD_W-1:0] res_in [3];
   logic [COORD_W-1:0] res_ff [3];
   logic [2:0] sat_in;
   logic wz_ff, ovf_ff, out_v_ff;
   div_type fin;
   assign fin = dst_ff[DIV_STAGES];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (fin.wz) begin
            res_in[c] = '0;
            sat_in[c] = 1'b0;
         end else if (fin.neg[c]) begin
            sat_in[c] = fin.big[c] || (fin.quo[c] > QBITS'(SAT_NEG));
            res_in[c] = sat_in[c] ? SAT_NEG : COORD_W'(-fin.quo[c]);
         end else begin
            sat_in[c] = fin.big[c] || (fin.quo[c] > QBITS'(SAT_POS));
            res_in[c] = sat_in[c] ? SAT_POS : fin.quo[c][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_ff[DIV_STAGES];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
         wz_ff  <= fin.wz;
         ovf_ff <= |sat_in;
      end
   end

   assign rsp_ch.valid    = out_v_ff;
   assign rsp_ch.out_x    = res_ff[0];
   assign rsp_ch.out_y    = res_ff[1];
   assign rsp_ch.out_z    = res_ff[2];
   assign rsp_ch.w_zero   = wz_ff;
   assign rsp_ch.overflow = ovf_ff;

`ifndef ASSERT_OFF
   a_wz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.w_zero |->
         rsp_ch.out_x == '0 && rsp_ch.out_y == '0 && rsp_ch.out_z == '0)
      else $error("w_zero result with nonzero coordinates");
   a_wz_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.w_zero && rsp_ch.overflow))
      else $error("w_zero and overflow both set");
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.overflow |->
         rsp_ch.out_x == SAT_POS || rsp_ch.out_x == SAT_NEG ||
         rsp_ch.out_y == SAT_POS || rsp_ch.out_y == SAT_NEG ||
         rsp_ch.out_z == SAT_POS || rsp_ch.out_z == SAT_NEG)
      else $error("overflow without a saturated coordinate");
   a_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_ch.valid)
      else $error("result right after reset");
`endif

endmodule
